/* hdl/jbr_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the JPEG bit reader.
package jbr_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int MAX_READ_BITS = 32;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int VALUE_W       = 32;
	localparam int CNT_W         = 6;

	localparam logic [7:0] BYTE_MARKER = 8'hFF;
	localparam logic [7:0] BYTE_STUFF  = 8'h00;

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_READ = 2'd1;
	localparam logic [1:0] MODE_SKIP = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_END      = 3'd1;
	localparam logic [2:0] ST_UNDERRUN = 3'd2;
	localparam logic [2:0] ST_DROP     = 3'd3;
	localparam logic [2:0] ST_BADLEN   = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       start;
		logic       fetch;
		logic       set_primed;
		logic       take;
		logic       take_one;
		logic       restore;
		logic       set_status;
		logic [2:0] status_code;
		logic       load_out;
	} jbr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic primed;
		logic end_seen;
		logic bidx_zero;
		logic can_fetch;
		logic queue_empty;
		logic stuff_hit;
		logic cur_is_target;
		logic rem_zero;
		logic byte_done;
		logic is_read;
		logic badlen;
	} jbr_stat_t;

endpackage

/* hdl/jpeg_bit_reader_destuff.sv */
// Sequence from request acceptance to result load: push, no-op and bad length go straight
// to the done state. A read primes, then takes runs of bits up to each byte boundary and
// drops stuffed bytes before done; a skip primes, aligns to a byte boundary when already
// primed, and passes over bytes until the target or the end before done.
// One request at a time; the next is accepted the cycle after its result loads,
// and a result still waiting holds the controller. Reset (asynchronous): queue empty.
module jpeg_bit_reader_destuff import jbr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         mode,
	input  logic [7:0]         byte_data,
	input  logic               end_mark,
	input  logic [CNT_W-1:0]   bit_count,
	input  logic               stuffing_on,
	input  logic [7:0]         target_byte,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [VALUE_W-1:0] value,
	output logic [CNT_W-1:0]   bits_got,
	output logic [2:0]         status,
	output logic               at_end
);

	jbr_cmd_t  cmd;
	jbr_stat_t stat;

	// Sequence each request
	jbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (mode),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold queue, bit position and result
	jbr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.byte_data   (byte_data),
		.end_mark    (end_mark),
		.bit_count   (bit_count),
		.stuffing_on (stuffing_on),
		.target_byte (target_byte),
		.value       (value),
		.bits_got    (bits_got),
		.status      (status),
		.at_end      (at_end)
	);

`ifndef SYNTHESIS
	a_got_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> bits_got <= CNT_W'(MAX_READ_BITS))
		else $error("bits_got above read limit");

	a_value_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (bits_got < CNT_W'(MAX_READ_BITS)) |-> (value >> bits_got) == '0)
		else $error("value wider than bits_got");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != ST_OK) && (status != ST_END) |-> value == '0 && bits_got == '0)
		else $error("failed request returned data");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");
`endif

endmodule

/* hdl/jbr_ctrl.sv */
// Request sequencing state machine for the JPEG bit reader.
module jbr_ctrl import jbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] mode,
	output logic       res_valid,
	input  logic       res_ready,
	input  jbr_stat_t  stat,
	output jbr_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PRIME = 6'b000010,
		S_READ  = 6'b000100,
		S_ALIGN = 6'b001000,
		S_SCAN  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					case (mode)
						MODE_READ: state_d = stat.badlen ? S_DONE : S_PRIME;
						MODE_SKIP: state_d = S_PRIME;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_PRIME: begin
				if (stat.primed) begin
					state_d = stat.is_read ? S_READ : S_ALIGN;
				end else if (stat.can_fetch) begin
					cmd.fetch      = 1'b1;
					cmd.set_primed = 1'b1;
					state_d        = stat.is_read ? S_READ : S_SCAN;
				end else begin
					cmd.restore     = stat.is_read;
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_UNDERRUN;
					state_d         = S_DONE;
				end
			end
			S_READ: begin
				if (stat.rem_zero) begin
					state_d = S_DONE;
				end else if (stat.end_seen) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_END;
					state_d         = S_DONE;
				end else if (stat.stuff_hit) begin
					// drop the stuffed zero byte; at the stream end take one bit of it
					if (stat.can_fetch) begin
						cmd.fetch    = 1'b1;
						cmd.take_one = stat.queue_empty;
					end else begin
						cmd.restore     = 1'b1;
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_UNDERRUN;
						state_d         = S_DONE;
					end
				end else if (stat.byte_done && !stat.can_fetch) begin
					cmd.restore     = 1'b1;
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_UNDERRUN;
					state_d         = S_DONE;
				end else begin
					cmd.take  = 1'b1;
					cmd.fetch = stat.byte_done;
				end
			end
			S_ALIGN: begin
				if (stat.bidx_zero) begin
					state_d = S_SCAN;
				end else if (stat.can_fetch) begin
					cmd.fetch = 1'b1;
					state_d   = S_SCAN;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_UNDERRUN;
					state_d         = S_DONE;
				end
			end
			S_SCAN: begin
				if (stat.end_seen) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_END;
					state_d         = S_DONE;
				end else if (stat.cur_is_target) begin
					state_d = S_DONE;
				end else if (stat.can_fetch) begin
					cmd.fetch = 1'b1;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_UNDERRUN;
					state_d         = S_DONE;
				end
			end
			S_DONE: begin
				if (!res_valid_q || res_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/jbr_dp.sv */
// Byte queue, bit position state and read accumulator for the JPEG bit reader.
module jbr_dp import jbr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  jbr_cmd_t           cmd,
	output jbr_stat_t          stat,
	input  logic [1:0]         mode,
	input  logic [7:0]         byte_data,
	input  logic               end_mark,
	input  logic [CNT_W-1:0]   bit_count,
	input  logic               stuffing_on,
	input  logic [7:0]         target_byte,
	output logic [VALUE_W-1:0] value,
	output logic [CNT_W-1:0]   bits_got,
	output logic [2:0]         status,
	output logic               at_end
);

	logic [7:0]        queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QLVL_W-1:0] level_q;
	logic [7:0]        cur_q, prev_q;
	logic [2:0]        bidx_q;
	logic              primed_q, end_seen_q, end_queued_q;

	logic [QPTR_W-1:0] head_snap_q;
	logic [QLVL_W-1:0] level_snap_q;
	logic [7:0]        cur_snap_q, prev_snap_q;
	logic [2:0]        bidx_snap_q;
	logic              primed_snap_q, end_seen_snap_q;

	logic               is_read_q, stuffing_q;
	logic [7:0]         target_q;
	logic [CNT_W-1:0]   rem_q, got_q;
	logic [VALUE_W-1:0] acc_q;
	logic [2:0]         res_status_q;

	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   bits_got_q;
	logic [2:0]         status_q;
	logic               at_end_q;

	logic [QPTR_W-1:0]  head_inc;
	logic [QPTR_W:0]    tail_sum;
	logic [QPTR_W-1:0]  tail;
	logic               push_ok, push_drop;
	logic [3:0]         avail, take_n;
	logic [7:0]         shifted, field;
	logic [VALUE_W-1:0] acc_next;

	// Queue pointers
	always_comb begin
		head_inc = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_sum = (QPTR_W + 1)'(head_q) + (QPTR_W + 1)'(level_q);
		if (tail_sum >= (QPTR_W + 1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (QPTR_W + 1)'(QUEUE_DEPTH);
		end
		tail = tail_sum[QPTR_W-1:0];
	end

	assign push_drop = end_queued_q || (level_q >= QLVL_W'(QUEUE_DEPTH));
	assign push_ok   = cmd.start && (mode == MODE_PUSH) && !end_mark && !push_drop;

	// Take the next run of bits up to the byte boundary
	always_comb begin
		avail    = 4'd8 - {1'b0, bidx_q};
		take_n   = (rem_q < {2'b00, avail}) ? rem_q[3:0] : avail;
		shifted  = cur_q << bidx_q;
		field    = shifted >> (4'd8 - take_n);
		acc_next = (acc_q << take_n) | {{(VALUE_W - 8){1'b0}}, field};
	end

	always_comb begin
		stat.primed        = primed_q;
		stat.end_seen      = end_seen_q;
		stat.bidx_zero     = (bidx_q == 3'd0);
		stat.can_fetch     = (level_q != '0) || end_queued_q;
		stat.queue_empty   = (level_q == '0);
		stat.stuff_hit     = stuffing_q && (prev_q == BYTE_MARKER) && (cur_q == BYTE_STUFF);
		stat.cur_is_target = (cur_q == target_q);
		stat.rem_zero      = (rem_q == '0);
		stat.byte_done     = (take_n == avail);
		stat.is_read       = is_read_q;
		stat.badlen        = (bit_count > CNT_W'(MAX_READ_BITS));
	end

	// Reader state: push, fetch, advance, restore
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			level_q      <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
			bidx_q       <= '0;
			primed_q     <= 1'b0;
			end_seen_q   <= 1'b0;
			end_queued_q <= 1'b0;
		end else if (cmd.restore) begin
			head_q     <= head_snap_q;
			level_q    <= level_snap_q;
			cur_q      <= cur_snap_q;
			prev_q     <= prev_snap_q;
			bidx_q     <= bidx_snap_q;
			primed_q   <= primed_snap_q;
			end_seen_q <= end_seen_snap_q;
		end else begin
			if (cmd.start && (mode == MODE_PUSH) && end_mark) begin
				end_queued_q <= 1'b1;
			end
			if (push_ok) begin
				level_q <= level_q + 1'b1;
			end
			if (cmd.set_primed) begin
				primed_q <= 1'b1;
			end
			if (cmd.fetch) begin
				prev_q <= cur_q;
				// one bit of the kept byte is taken when the fetch reaches the end
				bidx_q <= {2'b00, cmd.take_one};
				if (level_q != '0) begin
					cur_q   <= queue_q[head_q];
					head_q  <= head_inc;
					level_q <= level_q - 1'b1;
				end else begin
					end_seen_q <= 1'b1;
				end
			end else if (cmd.take) begin
				bidx_q <= bidx_q + take_n[2:0];
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			queue_q[tail] <= byte_data;
		end
	end

	// Request latch, snapshot, accumulator and result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is_read_q       <= (mode == MODE_READ);
			stuffing_q      <= stuffing_on;
			target_q        <= target_byte;
			rem_q           <= bit_count;
			got_q           <= '0;
			acc_q           <= '0;
			head_snap_q     <= head_q;
			level_snap_q    <= level_q;
			cur_snap_q      <= cur_q;
			prev_snap_q     <= prev_q;
			bidx_snap_q     <= bidx_q;
			primed_snap_q   <= primed_q;
			end_seen_snap_q <= end_seen_q;
			if ((mode == MODE_PUSH) && !end_mark && push_drop) begin
				res_status_q <= ST_DROP;
			end else if ((mode == MODE_READ) && stat.badlen) begin
				res_status_q <= ST_BADLEN;
			end else begin
				res_status_q <= ST_OK;
			end
		end else begin
			if (cmd.restore) begin
				acc_q <= '0;
				got_q <= '0;
			end else if (cmd.take) begin
				acc_q <= acc_next;
				rem_q <= rem_q - CNT_W'(take_n);
				got_q <= got_q + CNT_W'(take_n);
			end else if (cmd.take_one) begin
				acc_q <= {acc_q[VALUE_W-2:0], cur_q[7]};
				rem_q <= rem_q - 1'b1;
				got_q <= got_q + 1'b1;
			end
			if (cmd.set_status) begin
				res_status_q <= cmd.status_code;
			end
		end
		if (cmd.load_out) begin
			value_q    <= acc_q;
			bits_got_q <= got_q;
			status_q   <= res_status_q;
			at_end_q   <= end_seen_q;
		end
	end

	assign value    = value_q;
	assign bits_got = bits_got_q;
	assign status   = status_q;
	assign at_end   = at_end_q;

endmodule

/* verif/jbr_read_checker.sv */
// Request/result monitor for the JPEG bit reader: predicts each result and compares it.
module jbr_read_checker import jbr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [1:0]         mode,
	input  logic [7:0]         byte_data,
	input  logic               end_mark,
	input  logic [CNT_W-1:0]   bit_count,
	input  logic               stuffing_on,
	input  logic [7:0]         target_byte,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic [VALUE_W-1:0] value,
	input  logic [CNT_W-1:0]   bits_got,
	input  logic [2:0]         status,
	input  logic               at_end,
	output int                 errors,
	output int                 results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   got;
		logic [2:0]         status;
		logic               at_end;
	} read_result_t;

	// Mirror of the reader state
	logic [7:0]   pend_bytes[$];
	logic [7:0]   cur_byte;
	logic [7:0]   prev_byte;
	int unsigned  bit_pos;
	bit           primed_f;
	bit           end_reached;
	bit           end_marked;

	read_result_t results_owed[$];

	// Advance to the next byte; at an empty queue with the end mark queued, flag the end
	function automatic bit pull_byte();
		if (pend_bytes.size() > 0) begin
			prev_byte = cur_byte;
			cur_byte  = pend_bytes.pop_front();
			bit_pos   = 0;
			return 1'b1;
		end
		if (end_marked) begin
			prev_byte   = cur_byte;
			bit_pos     = 0;
			end_reached = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Fetch the very first byte once
	function automatic bit ensure_primed();
		if (!primed_f) begin
			if (!pull_byte())
				return 1'b0;
			primed_f = 1'b1;
		end
		return 1'b1;
	endfunction

	// Work out the result of one request and update the mirrored state
	function automatic read_result_t step_reader(input logic [1:0] m, input logic [7:0] b,
			input logic e, input logic [CNT_W-1:0] n, input logic s, input logic [7:0] t);
		read_result_t r;
		logic [7:0]   keep_bytes[$];
		logic [7:0]   keep_cur;
		logic [7:0]   keep_prev;
		int unsigned  keep_pos;
		bit           keep_primed;
		bit           keep_end;
		bit           ok;
		r = '0;
		case (m)
			MODE_PUSH: begin
				if (e)
					end_marked = 1'b1;
				else if (end_marked || pend_bytes.size() >= QUEUE_DEPTH)
					r.status = ST_DROP;
				else
					pend_bytes.push_back(b);
			end
			MODE_READ: begin
				if (n > MAX_READ_BITS) begin
					r.status = ST_BADLEN;
				end else begin
					// hold a copy so that an underrun can undo the whole read
					keep_bytes  = pend_bytes;
					keep_cur    = cur_byte;
					keep_prev   = prev_byte;
					keep_pos    = bit_pos;
					keep_primed = primed_f;
					keep_end    = end_reached;
					ok = ensure_primed();
					for (int i = 0; ok && i < n; i++) begin
						if (end_reached) begin
							r.status = ST_END;
							break;
						end
						// drop the stuffed zero after a marker byte
						if (s && prev_byte == BYTE_MARKER && cur_byte == BYTE_STUFF) begin
							if (!pull_byte()) begin
								ok = 1'b0;
								break;
							end
						end
						r.value = {r.value[VALUE_W-2:0], cur_byte[7 - bit_pos]};
						r.got   = r.got + 1'b1;
						bit_pos = bit_pos + 1;
						if (bit_pos == 8) begin
							if (!pull_byte()) begin
								ok = 1'b0;
								break;
							end
						end
					end
					if (!ok) begin
						pend_bytes  = keep_bytes;
						cur_byte    = keep_cur;
						prev_byte   = keep_prev;
						bit_pos     = keep_pos;
						primed_f    = keep_primed;
						end_reached = keep_end;
						r           = '0;
						r.status    = ST_UNDERRUN;
					end
				end
			end
			MODE_SKIP: begin
				if (!ensure_primed()) begin
					r.status = ST_UNDERRUN;
				end else if (bit_pos != 0 && !pull_byte()) begin
					r.status = ST_UNDERRUN;
				end else begin
					// skipped bytes stay skipped, even on underrun
					while (!end_reached && cur_byte != t) begin
						if (!pull_byte()) begin
							r.status = ST_UNDERRUN;
							break;
						end
					end
					if (r.status == ST_OK && end_reached)
						r.status = ST_END;
				end
			end
			default: ;
		endcase
		r.at_end = end_reached;
		return r;
	endfunction

	// Compare results first: a result never belongs to a request accepted on the same edge
	always @(posedge clk) begin : watch_channels
		read_result_t due;
		if (!arst_n) begin
			pend_bytes.delete();
			results_owed.delete();
			cur_byte    = '0;
			prev_byte   = '0;
			bit_pos     = 0;
			primed_f    = 1'b0;
			end_reached = 1'b0;
			end_marked  = 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (results_owed.size() == 0) begin
					$error("result with no request outstanding: value %h status %0d",
						value, status);
					errors = errors + 1;
				end else begin
					due = results_owed.pop_front();
					if (due.value !== value) begin
						$error("value: expected %h, actual %h", due.value, value);
						errors = errors + 1;
					end
					if (due.got !== bits_got) begin
						$error("bits_got: expected %0d, actual %0d", due.got, bits_got);
						errors = errors + 1;
					end
					if (due.status !== status) begin
						$error("status: expected %0d, actual %0d", due.status, status);
						errors = errors + 1;
					end
					if (due.at_end !== at_end) begin
						$error("at_end: expected %0d, actual %0d", due.at_end, at_end);
						errors = errors + 1;
					end
				end
			end
			if (req_valid && req_ready)
				results_owed.push_back(step_reader(mode, byte_data, end_mark, bit_count,
					stuffing_on, target_byte));
		end
		results_due = results_owed.size();
	end

endmodule

/* verif/tb_top.sv */
// Testbench top for the JPEG bit reader: clock, reset, request stimulus, result sink, verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jbr_pkg::*;

	localparam logic [1:0] MODE_IDLE  = 2'd3;
	localparam int         RANDOM_OPS = 880;
	localparam int         IDLE_LIMIT = 1000;
	localparam int         SETTLE     = 30;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               req_valid   = 1'b0;
	logic               req_ready;
	logic [1:0]         mode        = '0;
	logic [7:0]         byte_data   = '0;
	logic               end_mark    = 1'b0;
	logic [CNT_W-1:0]   bit_count   = '0;
	logic               stuffing_on = 1'b0;
	logic [7:0]         target_byte = '0;
	logic               res_valid;
	logic               res_ready   = 1'b0;
	logic [VALUE_W-1:0] value;
	logic [CNT_W-1:0]   bits_got;
	logic [2:0]         status;
	logic               at_end;
	int                 errors;
	int                 results_due;

	bit                 tx_quiet    = 1'b0;
	bit                 rx_quiet    = 1'b0;
	int unsigned        rx_hold     = 0;
	int                 idle_cycles = 0;

	logic [7:0] opening_bytes [8] = '{8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01};

	jpeg_bit_reader_destuff dut (.*);

	jbr_read_checker checker_i (.*);

	always #10 clk = ~clk;

	// Present one request after a random gap and hold it until accepted
	task automatic send_req(input logic [1:0] m, input logic [7:0] b, input logic e,
			input logic [CNT_W-1:0] n, input logic s, input logic [7:0] t);
		int unsigned gap;
		if ($urandom_range(0, 31) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		mode        <= m;
		byte_data   <= b;
		end_mark    <= e;
		bit_count   <= n;
		stuffing_on <= s;
		target_byte <= t;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_req(MODE_PUSH, b, 1'b0, CNT_W'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic read_bits(input logic [CNT_W-1:0] n, input logic s);
		send_req(MODE_READ, 8'($urandom), 1'($urandom), n, s, 8'($urandom));
	endtask

	task automatic skip_to(input logic [7:0] t);
		send_req(MODE_SKIP, 8'($urandom), 1'($urandom), CNT_W'($urandom), 1'($urandom), t);
	endtask

	task automatic push_end_mark();
		send_req(MODE_PUSH, 8'($urandom), 1'b1, CNT_W'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// Stop sending and wait until every request has had its result
	task automatic drain_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Favour marker and stuffing bytes so that destuffing is exercised often
	function automatic logic [7:0] stream_byte();
		case ($urandom_range(0, 3))
			0: return BYTE_MARKER;
			1: return BYTE_STUFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Accept results after a random stall, with stretches of no stall
	always @(posedge clk) begin : result_sink
		int unsigned hold;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if ($urandom_range(0, 15) == 0)
					rx_quiet = !rx_quiet;
				hold = rx_quiet ? 0 : $urandom_range(0, 5);
				rx_hold   <= hold;
				res_ready <= (hold == 0);
			end else if (rx_hold != 0) begin
				rx_hold   <= rx_hold - 1;
				res_ready <= (rx_hold == 1);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("jpeg_bit_reader_destuff verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Underrun on an empty queue, unused mode, bad lengths
		read_bits(6'd8, 1'b1);
		skip_to(BYTE_STUFF);
		send_req(MODE_IDLE, 8'hFF, 1'b1, 6'd63, 1'b1, 8'hFF);
		read_bits(6'd33, 1'b0);
		read_bits(6'd63, 1'b1);

		// Stream with stuffed zeros after markers, then zero-length, full and cancelled reads
		foreach (opening_bytes[i])
			push_byte(opening_bytes[i]);
		read_bits(6'd0, 1'b1);
		read_bits(6'd32, 1'b1);
		read_bits(6'd16, 1'b0);
		push_byte(8'h7E);
		push_byte(8'hC3);
		read_bits(6'd16, 1'b0);
		skip_to(8'hC3);
		read_bits(6'd32, 1'b0);

		// Random mix of pushes, reads, skips, no-ops and bad lengths, with bursts that fill the queue
		for (int k = 0; k < RANDOM_OPS; k++) begin
			if (k % 300 == 150)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 1)
				repeat (QUEUE_DEPTH + 2) push_byte(stream_byte());
			else if (pick < 54)
				push_byte(stream_byte());
			else if (pick < 87)
				read_bits(CNT_W'($urandom_range(0, MAX_READ_BITS)), 1'($urandom));
			else if (pick < 93)
				skip_to($urandom_range(0, 1) ? stream_byte() : 8'($urandom));
			else if (pick < 96)
				send_req(MODE_IDLE, 8'($urandom), 1'($urandom), CNT_W'($urandom),
					1'($urandom), 8'($urandom));
			else
				read_bits(CNT_W'($urandom_range(MAX_READ_BITS + 1, 63)), 1'($urandom));
		end

		// Close the stream: drops after the end mark, short reads, skip at the end
		push_byte(BYTE_MARKER);
		push_end_mark();
		push_byte(8'h5A);
		push_end_mark();
		repeat (6) read_bits(6'd32, 1'b1);
		skip_to(BYTE_MARKER);
		read_bits(6'd0, 1'b0);

		drain_results();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("jpeg_bit_reader_destuff verification clean");
		else
			$display("jpeg_bit_reader_destuff verification failed");
		$finish;
	end

endmodule
